// ----- src/fir_linear_convolution_unit_macros.svh -----
// assertion macros used by the convolution unit back end rtl
`ifndef FIR_LINEAR_CONVOLUTION_UNIT_MACROS_SVH
`define FIR_LINEAR_CONVOLUTION_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FLC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/flc_pkg.sv -----
// shared constants, types and helpers of the convolution unit
`default_nettype none

package flc_pkg;

    // tap store size, a power of two so history pointers wrap by themselves
    localparam int MAX_TAPS    = 32;
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);

    // field widths
    localparam int CFG_W       = 6;
    localparam int IDX_W       = 5;
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 37;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [IDX_W-1:0]            tap_index;
        logic signed [SAMPLE_W-1:0]  value;
        logic                        first;
        logic                        last;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } back_state_t;

    // taps in use: zero acts as one, anything above the store acts as full
    function automatic logic [CNT_W-1:0] taps_in_use(input logic [CFG_W-1:0] tc);
        logic [CNT_W-1:0] m;
        m = CNT_W'(tc);
        if (tc == '0)
        begin
            m = CNT_W'(1);
        end
        else if (int'(tc) > MAX_TAPS)
        begin
            m = CNT_W'(MAX_TAPS);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/flc_in_if.sv -----
// command channel: coefficient loads and sample pushes
`default_nettype none

interface flc_in_if import flc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [IDX_W-1:0]           tap_index;
    logic signed [SAMPLE_W-1:0] sample_or_coef;
    logic                       first;
    logic                       last;

    modport source (output valid, cmd, tap_index, sample_or_coef, first, last, input ready);
    modport sink   (input valid, cmd, tap_index, sample_or_coef, first, last, output ready);
endinterface

`default_nettype wire

// ----- src/flc_out_if.sv -----
// result channel: convolution outputs
`default_nettype none

interface flc_out_if import flc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] conv_out;
    logic                    out_last;

    modport source (output valid, conv_out, out_last, input ready);
    modport sink   (input valid, conv_out, out_last, output ready);
endinterface

`default_nettype wire

// ----- src/flc_cfg_if.sv -----
// configuration write channel for the tap count register
`default_nettype none

interface flc_cfg_if import flc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

`default_nettype wire

// ----- src/flc_front.sv -----
// front end: takes requests, classifies them, holds the tap count register
`default_nettype none

module flc_front import flc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    flc_in_if.sink                 item,
    flc_cfg_if.sink                cfg,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output cmd_t                   push_data,
    output logic [CNT_W-1:0]       taps
);

    logic [CFG_W-1:0] tap_count_reg;

    // tap count register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CFG_W'(1);
        end
        else if (cfg.valid)
        begin
            tap_count_reg <= cfg.tap_count;
        end
    end

    assign taps = taps_in_use(tap_count_reg);

    // classify the request; flags mean nothing on a load
    always_comb
    begin
        push_data.op        = item.cmd ? OP_SAMPLE : OP_LOAD;
        push_data.tap_index = item.tap_index;
        push_data.value     = item.sample_or_coef;
        push_data.first     = item.cmd & item.first;
        push_data.last      = item.cmd & item.last;
    end

    assign push_valid = item.valid;
    assign item.ready = push_ready;

endmodule

`default_nettype wire

// ----- src/flc_queue.sv -----
// short command queue between front and back
`default_nettype none

module flc_queue import flc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_data
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/flc_back.sv -----
// back end: tap store, history ring and the shared multiply-accumulate loop
`default_nettype none

`include "fir_linear_convolution_unit_macros.svh"

module flc_back import flc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  cmd_t                   pop_data,
    input  wire logic [CNT_W-1:0]  taps,
    flc_out_if.source              result
);

    back_state_t state_reg, state_next;
    logic [TAP_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  m_reg, m_next;
    logic [TAP_W-1:0]  tail_reg, tail_next;
    logic              last_reg, last_next;
    logic [TAP_W-1:0]  wptr_reg, wptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] coef_reg [MAX_TAPS];

    logic signed [SAMPLE_W-1:0] hist_rd_reg;
    logic signed [SAMPLE_W-1:0] coef_rd_reg;
    logic                       zero_reg;
    logic                       rd_vld_reg;
    logic signed [PROD_W-1:0]   mult;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_vld_reg;
    logic signed [SUM_W-1:0]    acc_reg;

    logic                       out_valid_reg;
    logic signed [SUM_W-1:0]    conv_out_reg;
    logic                       out_last_reg;

    logic                       pop;
    logic                       out_free;
    logic                       issue;
    logic                       hist_we;
    logic signed [SAMPLE_W-1:0] hist_wdata;
    logic [TAP_W-1:0]           hist_waddr;
    logic [TAP_W-1:0]           hist_raddr;
    logic                       coef_we;
    logic                       acc_clr;
    logic                       out_load;
    logic [CNT_W-1:0]           fill_inc;

    assign pop_ready  = (state_reg == ST_IDLE);
    assign pop        = pop_valid & pop_ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign issue      = (state_reg == ST_MAC);
    assign hist_waddr = wptr_reg + TAP_W'(1);
    assign hist_raddr = wptr_reg - k_reg;
    assign fill_inc   = (fill_reg == CNT_W'(MAX_TAPS)) ? fill_reg : fill_reg + CNT_W'(1);

    // sequencer: next state and strobes
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        tail_next  = tail_reg;
        last_next  = last_reg;
        wptr_next  = wptr_reg;
        fill_next  = fill_reg;
        hist_we    = 1'b0;
        hist_wdata = '0;
        coef_we    = 1'b0;
        acc_clr    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (pop_data.op == OP_SAMPLE)
                    begin
                        hist_we    = 1'b1;
                        hist_wdata = pop_data.value;
                        wptr_next  = hist_waddr;
                        fill_next  = pop_data.first ? CNT_W'(1) : fill_inc;
                        m_next     = taps;
                        tail_next  = pop_data.last ? TAP_W'(taps - CNT_W'(1)) : '0;
                        last_next  = pop_data.last;
                        k_next     = '0;
                        acc_clr    = 1'b1;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        coef_we = 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                k_next = k_reg + TAP_W'(1);
                if (CNT_W'(k_reg) == m_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (tail_reg != '0)
                    begin
                        // tail output: shift a zero in and run the taps again
                        hist_we    = 1'b1;
                        hist_wdata = '0;
                        wptr_next  = hist_waddr;
                        fill_next  = fill_inc;
                        tail_next  = tail_reg - TAP_W'(1);
                        k_next     = '0;
                        acc_clr    = 1'b1;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            m_reg        <= CNT_W'(1);
            tail_reg     <= '0;
            last_reg     <= 1'b0;
            wptr_reg     <= '0;
            fill_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            m_reg        <= m_next;
            tail_reg     <= tail_next;
            last_reg     <= last_next;
            wptr_reg     <= wptr_next;
            fill_reg     <= fill_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tap store, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_we)
        begin
            coef_reg[TAP_W'(pop_data.tap_index)] <= pop_data.value;
        end
    end

    // history ring; entries past the fill count read as zero
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[hist_raddr];
        coef_rd_reg <= coef_reg[k_reg];
        zero_reg    <= !(CNT_W'(k_reg) < fill_reg);
    end

    // multiply stage
    assign mult = hist_rd_reg * coef_rd_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= zero_reg ? '0 : mult;
    end

    // accumulate stage
    always_ff @(posedge clk)
    begin
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            conv_out_reg <= acc_reg;
            out_last_reg <= last_reg && (tail_reg == '0);
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.conv_out = conv_out_reg;
    assign result.out_last = out_last_reg;

    // checks
    `FLC_ASSERT_IMPLIES(a_emit_drained, out_load, !rd_vld_reg && !prod_vld_reg, "sum emitted before pipeline drained")
    `FLC_ASSERT_IMPLIES(a_tap_in_range, state_reg == ST_MAC, CNT_W'(k_reg) < m_reg, "tap index past taps in use")
    `FLC_ASSERT_NEXT(a_first_fill, pop && pop_data.op == OP_SAMPLE && pop_data.first, fill_reg == CNT_W'(1), "history not restarted on first")
    `FLC_ASSERT_IMPLIES(a_idle_empty, state_reg == ST_IDLE, !rd_vld_reg && !prod_vld_reg, "pipeline busy while idle")

endmodule

`default_nettype wire

// ----- src/fir_linear_convolution_unit.sv -----
// top level of the direct-form fir convolution unit
//
//   channel  role    payload
//   item     sink    cmd, tap_index, sample_or_coef, first, last
//   result   source  conv_out, out_last
//   cfg      sink    tap_count
//
// a coefficient load is written into the tap store in the back end as it leaves the queue
// each output for m taps in use, tail outputs too, is made as follows:
//   one multiply-accumulate unit walks the taps, then three pipeline stages drain
// a sample with last gives m outputs back to back through the same loop
// reset is immediate: tap store clears at once, history is ruled empty by a fill count
// a stalled result holds the back end; the front keeps taking requests until the queue fills
`default_nettype none

module fir_linear_convolution_unit import flc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    flc_in_if.sink    item,
    flc_out_if.source result,
    flc_cfg_if.sink   cfg
);

    logic             push_valid;
    logic             push_ready;
    cmd_t             push_data;
    logic             pop_valid;
    logic             pop_ready;
    cmd_t             pop_data;
    logic [CNT_W-1:0] taps;

    // request intake and tap count register
    flc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .taps       (taps)
    );

    // decoupling queue
    flc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // execution: tap store, history and multiply-accumulate
    flc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .taps      (taps),
        .result    (result)
    );

endmodule

`default_nettype wire
